// File: rtl/project_box_to_screen_rect_top_macros.svh
// Assertion macros used by the box projection top level.
`ifndef PROJECT_BOX_TO_SCREEN_RECT_TOP_MACROS_SVH
`define PROJECT_BOX_TO_SCREEN_RECT_TOP_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define PBSR_CHK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pbsr check failed");

// next-cycle implication
`define PBSR_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pbsr check failed");

`endif

// File: rtl/pbsr_pkg.sv
// Types and constants for the box projection pipeline.
package pbsr_pkg;

  localparam int COORD_W     = 32;
  localparam int CLIP_W      = 49;
  localparam int MAG_W       = 48;
  localparam int QBITS       = 32;
  localparam int FRAC        = 16;
  localparam int NCH         = 3;
  localparam int NUM_CORNERS = 8;
  localparam int CORNER_W    = 3;
  localparam int CNT_W       = 4;
  localparam int DIM_W       = 14;
  localparam int PIX_W       = 48;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 64;

  localparam logic signed [COORD_W-1:0] ONE_Q16  = 32'sd65536;
  localparam logic signed [COORD_W-1:0] NEG_ONE  = -32'sd65536;
  localparam logic signed [COORD_W-1:0] SAT_MAX  = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] SAT_MIN  = 32'sh8000_0000;

  typedef enum logic [CORNER_W-1:0] {
    REG_ROW0_XY, REG_ROW0_ZW, REG_ROW1_XY, REG_ROW1_ZW,
    REG_ROW2_XY, REG_ROW2_ZW, REG_ROW3_XY, REG_ROW3_ZW
  } reg_idx_e;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [3:0][3:0][COORD_W-1:0] mat_t;

  typedef struct packed {
    logic vld;
    logic last;
    logic live;
  } tok_t;

  typedef struct packed {
    tok_t tok;
    logic wnz;
    logic wpos;
  } side_t;

  typedef struct packed {
    mag_t mc;
    logic neg;
    logic ovf;
  } div_in_t;

  typedef struct packed {
    logic [QBITS-1:0] q;
    logic             neg;
    logic             ovf;
  } div_out_t;

  function automatic coord_t sat32(input logic signed [PIX_W-1:0] v);
    coord_t r;
    if (v > PIX_W'(SAT_MAX)) r = SAT_MAX;
    else if (v < PIX_W'(SAT_MIN)) r = SAT_MIN;
    else r = v[COORD_W-1:0];
    return r;
  endfunction

endpackage

// File: rtl/pbsr_seq.sv
// Corner sequencer: holds one box and issues its eight corners, one per cycle while adv_i is high.
module pbsr_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pbsr_pkg::coord_t box_min_x_i,
  input  pbsr_pkg::coord_t box_min_y_i,
  input  pbsr_pkg::coord_t box_min_z_i,
  input  pbsr_pkg::coord_t box_max_x_i,
  input  pbsr_pkg::coord_t box_max_y_i,
  input  pbsr_pkg::coord_t box_max_z_i,
  input  logic            box_valid_i,
  output pbsr_pkg::tok_t   tok_o,
  output pbsr_pkg::coord_t px_o,
  output pbsr_pkg::coord_t py_o,
  output pbsr_pkg::coord_t pz_o
);
  import pbsr_pkg::*;

  logic                busy_q, busy_d;
  logic [CORNER_W-1:0] k_q, k_d;
  logic                last_k, take;
  coord_t              lo_x_q, lo_y_q, lo_z_q, hi_x_q, hi_y_q, hi_z_q;
  logic                live_q;
  tok_t                tok_q;
  coord_t              px_q, py_q, pz_q;

  assign last_k     = (k_q == CORNER_W'(NUM_CORNERS - 1));
  assign in_ready_o = adv_i && (!busy_q || last_k);
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    busy_d = busy_q;
    k_d    = k_q;
    if (adv_i && busy_q) begin
      k_d = k_q + 1'b1;
      if (last_k) busy_d = 1'b0;
    end
    if (take) begin
      busy_d = 1'b1;
      k_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
      tok_q  <= '0;
    end else begin
      busy_q <= busy_d;
      k_q    <= k_d;
      if (adv_i) begin
        tok_q.vld  <= busy_q;
        tok_q.last <= last_k;
        tok_q.live <= live_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      lo_x_q <= box_min_x_i;
      lo_y_q <= box_min_y_i;
      lo_z_q <= box_min_z_i;
      hi_x_q <= box_max_x_i;
      hi_y_q <= box_max_y_i;
      hi_z_q <= box_max_z_i;
      live_q <= box_valid_i;
    end
    if (adv_i) begin
      // corner bit 2 picks x, bit 1 y, bit 0 z
      px_q <= k_q[2] ? hi_x_q : lo_x_q;
      py_q <= k_q[1] ? hi_y_q : lo_y_q;
      pz_q <= k_q[0] ? hi_z_q : lo_z_q;
    end
  end

  assign tok_o = tok_q;
  assign px_o  = px_q;
  assign py_o  = py_q;
  assign pz_o  = pz_q;

endmodule

// File: rtl/pbsr_clip.sv
// Matrix transform of one corner to clip space, then magnitudes for the divider.
module pbsr_clip (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  pbsr_pkg::mat_t      mat_i,
  input  pbsr_pkg::tok_t      tok_i,
  input  pbsr_pkg::coord_t    px_i,
  input  pbsr_pkg::coord_t    py_i,
  input  pbsr_pkg::coord_t    pz_i,
  output pbsr_pkg::side_t     side_o,
  output pbsr_pkg::mag_t      mw_o,
  output pbsr_pkg::div_in_t [2:0] chan_o
);
  import pbsr_pkg::*;

  // stage B: products
  tok_t                     b_tok_q;
  logic signed [63:0]       prod_q [4][NCH];
  // stage C: clip sums
  tok_t                     c_tok_q;
  logic signed [CLIP_W-1:0] clip_q [4];
  // stage D: magnitudes
  side_t                    d_side_q;
  mag_t                     d_mw_q;
  div_in_t [2:0]            d_chan_q;

  logic signed [CLIP_W-1:0] clip_d [4];
  logic signed [63:0]       fl [4][NCH];
  side_t                    side_d;
  mag_t                     mw_d;
  div_in_t [2:0]            chan_d;
  logic signed [CLIP_W-1:0] neg_v [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_tok_q  <= '0;
      c_tok_q  <= '0;
      d_side_q <= '0;
    end else if (adv_i) begin
      b_tok_q  <= tok_i;
      c_tok_q  <= b_tok_q;
      d_side_q <= side_d;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < NCH; c++) begin
        fl[r][c] = prod_q[r][c] >>> FRAC;
      end
      clip_d[r] = fl[r][0][CLIP_W-1:0] + fl[r][1][CLIP_W-1:0] + fl[r][2][CLIP_W-1:0]
                + {{(CLIP_W-COORD_W){mat_i[r][3][COORD_W-1]}}, mat_i[r][3]};
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      neg_v[r] = clip_q[r][CLIP_W-1] ? -clip_q[r] : clip_q[r];
    end
    mw_d            = neg_v[3][MAG_W-1:0];
    side_d.tok      = c_tok_q;
    side_d.wnz      = c_tok_q.live && (clip_q[3] != '0);
    side_d.wpos     = !clip_q[3][CLIP_W-1] && (clip_q[3] != '0);
    for (int i = 0; i < NCH; i++) begin
      chan_d[i].mc  = neg_v[i][MAG_W-1:0];
      chan_d[i].neg = clip_q[i][CLIP_W-1] ^ clip_q[3][CLIP_W-1];
      // quotient would need more than 32 bits
      chan_d[i].ovf = {16'b0, neg_v[i][MAG_W-1:0]} >= {mw_d, 16'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int r = 0; r < 4; r++) begin
        prod_q[r][0] <= $signed(mat_i[r][0]) * px_i;
        prod_q[r][1] <= $signed(mat_i[r][1]) * py_i;
        prod_q[r][2] <= $signed(mat_i[r][2]) * pz_i;
        clip_q[r]    <= clip_d[r];
      end
      d_mw_q   <= mw_d;
      d_chan_q <= chan_d;
    end
  end

  assign side_o = d_side_q;
  assign mw_o   = d_mw_q;
  assign chan_o = d_chan_q;

endmodule

// File: rtl/pbsr_div.sv
// Three restoring dividers sharing one divisor, one quotient bit per stage.
module pbsr_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  pbsr_pkg::side_t       side_i,
  input  pbsr_pkg::mag_t        mw_i,
  input  pbsr_pkg::div_in_t [2:0]  chan_i,
  output pbsr_pkg::side_t       side_o,
  output pbsr_pkg::div_out_t [2:0] res_o
);
  import pbsr_pkg::*;

  side_t            side_s [QBITS+1];
  mag_t             mw_s   [QBITS+1];
  mag_t             rem_s  [QBITS+1][NCH];
  logic [QBITS-1:0] dlo_s  [QBITS+1][NCH];
  logic [QBITS-1:0] quo_s  [QBITS+1][NCH];
  logic             neg_s  [QBITS+1][NCH];
  logic             ovf_s  [QBITS+1][NCH];

  always_comb begin
    side_s[0] = side_i;
    mw_s[0]   = mw_i;
    for (int c = 0; c < NCH; c++) begin
      rem_s[0][c] = {{FRAC{1'b0}}, chan_i[c].mc[MAG_W-1:FRAC]};
      dlo_s[0][c] = {chan_i[c].mc[FRAC-1:0], {(QBITS-FRAC){1'b0}}};
      quo_s[0][c] = '0;
      neg_s[0][c] = chan_i[c].neg;
      ovf_s[0][c] = chan_i[c].ovf;
    end
  end

  for (genvar s = 0; s < QBITS; s++) begin : g_stage
    logic [MAG_W:0] sh   [NCH];
    logic [MAG_W:0] df   [NCH];
    logic           take [NCH];

    always_comb begin
      for (int c = 0; c < NCH; c++) begin
        sh[c]   = {rem_s[s][c], dlo_s[s][c][QBITS-1]};
        df[c]   = sh[c] - {1'b0, mw_s[s]};
        take[c] = sh[c] >= {1'b0, mw_s[s]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_s[s+1] <= '0;
      end else if (adv_i) begin
        side_s[s+1] <= side_s[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        mw_s[s+1] <= mw_s[s];
        for (int c = 0; c < NCH; c++) begin
          rem_s[s+1][c] <= take[c] ? df[c][MAG_W-1:0] : sh[c][MAG_W-1:0];
          dlo_s[s+1][c] <= {dlo_s[s][c][QBITS-2:0], 1'b0};
          quo_s[s+1][c] <= {quo_s[s][c][QBITS-2:0], take[c]};
          neg_s[s+1][c] <= neg_s[s][c];
          ovf_s[s+1][c] <= ovf_s[s][c];
        end
      end
    end
  end

  assign side_o = side_s[QBITS];
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      res_o[c].q   = quo_s[QBITS][c];
      res_o[c].neg = neg_s[QBITS][c];
      res_o[c].ovf = ovf_s[QBITS][c];
    end
  end

endmodule

// File: rtl/pbsr_reduce.sv
// NDC saturation, per-box min/max and counts, pixel rectangle and result register.
module pbsr_reduce #(
  parameter int VIEW_WIDTH  = 640,
  parameter int VIEW_HEIGHT = 480
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  pbsr_pkg::side_t          side_i,
  input  pbsr_pkg::div_out_t [2:0] res_i,
  output logic                    out_valid_o,
  output logic                    projected_o,
  output logic                    view_hit_o,
  output logic [3:0]              corners_projected_o,
  output logic [3:0]              corners_inside_o,
  output pbsr_pkg::coord_t         depth_min_o,
  output pbsr_pkg::coord_t         depth_max_o,
  output pbsr_pkg::coord_t         pixel_left_o,
  output pbsr_pkg::coord_t         pixel_right_o,
  output pbsr_pkg::coord_t         pixel_top_o,
  output pbsr_pkg::coord_t         pixel_bottom_o
);
  import pbsr_pkg::*;

  localparam logic signed [DIM_W:0]     W_S   = (DIM_W+1)'(VIEW_WIDTH);
  localparam logic signed [DIM_W:0]     H_S   = (DIM_W+1)'(VIEW_HEIGHT);
  localparam logic signed [COORD_W-1:0] W_LIM = COORD_W'(VIEW_WIDTH * 65536);
  localparam logic signed [COORD_W-1:0] H_LIM = COORD_W'(VIEW_HEIGHT * 65536);
  localparam logic signed [COORD_W:0]   ONE_X = (COORD_W+1)'(ONE_Q16);

  // stage E: saturated NDC
  side_t  e_side_q;
  coord_t n_q [NCH];
  coord_t n_d [NCH];
  logic   cube;

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      if (res_i[i].ovf) n_d[i] = res_i[i].neg ? SAT_MIN : SAT_MAX;
      else if (res_i[i].neg) begin
        n_d[i] = (res_i[i].q > QBITS'(SAT_MIN)) ? SAT_MIN : -$signed(res_i[i].q);
      end else begin
        n_d[i] = res_i[i].q[QBITS-1] ? SAT_MAX : $signed(res_i[i].q);
      end
    end
  end

  // stage F: running reduction over a box
  logic [CNT_W-1:0] cnt_q, ins_q, cnt_n, ins_n;
  coord_t           mn_q [NCH];
  coord_t           mx_q [NCH];
  coord_t           mn_n [NCH];
  coord_t           mx_n [NCH];
  logic             proj, first;

  always_comb begin
    cube = 1'b1;
    for (int i = 0; i < NCH; i++) begin
      if (n_q[i] < NEG_ONE || n_q[i] > ONE_Q16) cube = 1'b0;
    end
    proj  = e_side_q.tok.vld && e_side_q.wnz;
    first = (cnt_q == '0);
    cnt_n = cnt_q + CNT_W'(proj);
    ins_n = ins_q + CNT_W'(proj && e_side_q.wpos && cube);
    for (int i = 0; i < NCH; i++) begin
      mn_n[i] = (proj && (first || n_q[i] < mn_q[i])) ? n_q[i] : mn_q[i];
      mx_n[i] = (proj && (first || n_q[i] > mx_q[i])) ? n_q[i] : mx_q[i];
    end
  end

  // stage G: finished box
  logic             g_vld_q;
  logic [CNT_W-1:0] g_cnt_q, g_ins_q;
  coord_t           g_mn_q [NCH];
  coord_t           g_mx_q [NCH];
  logic             box_done;

  assign box_done = e_side_q.tok.vld && e_side_q.tok.last;

  // stage H: viewport products
  logic                    h_vld_q;
  logic [CNT_W-1:0]        h_cnt_q, h_ins_q;
  coord_t                  h_dmin_q, h_dmax_q;
  logic signed [PIX_W-1:0] pl_q, pr_q, pt_q, pb_q;
  logic signed [COORD_W:0] sl, sr, st, sb;

  assign sl = {g_mn_q[0][COORD_W-1], g_mn_q[0]} + ONE_X;
  assign sr = {g_mx_q[0][COORD_W-1], g_mx_q[0]} + ONE_X;
  assign st = ONE_X - {g_mx_q[1][COORD_W-1], g_mx_q[1]};
  assign sb = ONE_X - {g_mn_q[1][COORD_W-1], g_mn_q[1]};

  // output stage
  logic   out_vld_q;
  logic   o_proj_q, o_ov_q;
  logic [CNT_W-1:0] o_cnt_q, o_ins_q;
  coord_t o_dmin_q, o_dmax_q, o_l_q, o_r_q, o_t_q, o_b_q;
  coord_t lft, rgt, top_v, bot_v;
  logic   ov, any;

  always_comb begin
    lft   = sat32(pl_q >>> 1);
    rgt   = sat32(pr_q >>> 1);
    top_v = sat32(pt_q >>> 1);
    bot_v = sat32(pb_q >>> 1);
    ov    = (rgt >= 0) && (lft <= W_LIM) && (bot_v >= 0) && (top_v <= H_LIM);
    any   = (h_cnt_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_side_q  <= '0;
      cnt_q     <= '0;
      ins_q     <= '0;
      g_vld_q   <= 1'b0;
      h_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv_i) begin
      e_side_q  <= side_i;
      g_vld_q   <= box_done;
      h_vld_q   <= g_vld_q;
      out_vld_q <= h_vld_q;
      if (box_done) begin
        cnt_q <= '0;
        ins_q <= '0;
      end else begin
        cnt_q <= cnt_n;
        ins_q <= ins_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      n_q     <= n_d;
      mn_q    <= mn_n;
      mx_q    <= mx_n;
      g_cnt_q <= cnt_n;
      g_ins_q <= ins_n;
      g_mn_q  <= mn_n;
      g_mx_q  <= mx_n;
      h_cnt_q <= g_cnt_q;
      h_ins_q <= g_ins_q;
      h_dmin_q <= g_mn_q[2];
      h_dmax_q <= g_mx_q[2];
      pl_q    <= sl * W_S;
      pr_q    <= sr * W_S;
      pt_q    <= st * H_S;
      pb_q    <= sb * H_S;
      o_proj_q <= any;
      o_ov_q   <= any && ov;
      o_cnt_q  <= h_cnt_q;
      o_ins_q  <= any ? h_ins_q : '0;
      o_dmin_q <= any ? h_dmin_q : '0;
      o_dmax_q <= any ? h_dmax_q : '0;
      o_l_q    <= any ? lft : '0;
      o_r_q    <= any ? rgt : '0;
      o_t_q    <= any ? top_v : '0;
      o_b_q    <= any ? bot_v : '0;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign projected_o         = o_proj_q;
  assign view_hit_o          = o_ov_q;
  assign corners_projected_o = o_cnt_q;
  assign corners_inside_o    = o_ins_q;
  assign depth_min_o         = o_dmin_q;
  assign depth_max_o         = o_dmax_q;
  assign pixel_left_o        = o_l_q;
  assign pixel_right_o       = o_r_q;
  assign pixel_top_o         = o_t_q;
  assign pixel_bottom_o      = o_b_q;

endmodule

// File: rtl/project_box_to_screen_rect_top.sv
// Top level: projects a world box through the clip matrix to a screen rectangle.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+----------------------------------------
//   in      | in  | in_valid_i/in_ready_o | box_min/max_x/y/z_i, box_valid_i
//   out     | out | out_valid_o/out_ready_i | projected_o .. pixel_bottom_o
//   cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i (always ready)
//
// A box holds the shared corner pipeline for its eight corners, one corner per cycle
// while the pipe advances, so a new request is taken only when idle or with the last
// corner of the previous box. The 32-stage divider is the longest part of the pipe.
// Reset loads the identity matrix and empties the pipe.
// A held result stalls the whole pipe; nothing is dropped or repeated.
`include "project_box_to_screen_rect_top_macros.svh"

module project_box_to_screen_rect_top #(
  parameter int VIEW_WIDTH  = 640,
  parameter int VIEW_HEIGHT = 480
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  pbsr_pkg::coord_t                     box_min_x_i,
  input  pbsr_pkg::coord_t                     box_min_y_i,
  input  pbsr_pkg::coord_t                     box_min_z_i,
  input  pbsr_pkg::coord_t                     box_max_x_i,
  input  pbsr_pkg::coord_t                     box_max_y_i,
  input  pbsr_pkg::coord_t                     box_max_z_i,
  input  logic                                box_valid_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                projected_o,
  output logic                                view_hit_o,
  output logic [3:0]                          corners_projected_o,
  output logic [3:0]                          corners_inside_o,
  output pbsr_pkg::coord_t                     depth_min_o,
  output pbsr_pkg::coord_t                     depth_max_o,
  output pbsr_pkg::coord_t                     pixel_left_o,
  output pbsr_pkg::coord_t                     pixel_right_o,
  output pbsr_pkg::coord_t                     pixel_top_o,
  output pbsr_pkg::coord_t                     pixel_bottom_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pbsr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pbsr_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import pbsr_pkg::*;

  // identity, row 3 first
  localparam mat_t MAT_RST = {
    ONE_Q16, 32'd0,   32'd0,   32'd0,
    32'd0,   ONE_Q16, 32'd0,   32'd0,
    32'd0,   32'd0,   ONE_Q16, 32'd0,
    32'd0,   32'd0,   32'd0,   ONE_Q16
  };

  mat_t          mat_q, mat_d;
  logic          adv;
  tok_t          a_tok;
  coord_t        a_px, a_py, a_pz;
  side_t         d_side, q_side;
  mag_t          d_mw;
  div_in_t [2:0] d_chan;
  div_out_t [2:0] q_res;

  assign cfg_ready_o = 1'b1;
  // the whole pipe moves unless a result is held
  assign adv = !out_valid_o || out_ready_i;

  always_comb begin
    mat_d = mat_q;
    if (cfg_valid_i && cfg_index_i[CFG_IDX_W-1:CORNER_W] == '0) begin
      unique case (reg_idx_e'(cfg_index_i[CORNER_W-1:0]))
        REG_ROW0_XY: mat_d[0][1:0] = cfg_data_i;
        REG_ROW0_ZW: mat_d[0][3:2] = cfg_data_i;
        REG_ROW1_XY: mat_d[1][1:0] = cfg_data_i;
        REG_ROW1_ZW: mat_d[1][3:2] = cfg_data_i;
        REG_ROW2_XY: mat_d[2][1:0] = cfg_data_i;
        REG_ROW2_ZW: mat_d[2][3:2] = cfg_data_i;
        REG_ROW3_XY: mat_d[3][1:0] = cfg_data_i;
        REG_ROW3_ZW: mat_d[3][3:2] = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= MAT_RST;
    end else begin
      mat_q <= mat_d;
    end
  end

  pbsr_seq u_seq (
    .clk_i, .rst_ni, .adv_i(adv),
    .in_valid_i, .in_ready_o,
    .box_min_x_i, .box_min_y_i, .box_min_z_i,
    .box_max_x_i, .box_max_y_i, .box_max_z_i, .box_valid_i,
    .tok_o(a_tok), .px_o(a_px), .py_o(a_py), .pz_o(a_pz)
  );

  pbsr_clip u_clip (
    .clk_i, .rst_ni, .adv_i(adv), .mat_i(mat_q),
    .tok_i(a_tok), .px_i(a_px), .py_i(a_py), .pz_i(a_pz),
    .side_o(d_side), .mw_o(d_mw), .chan_o(d_chan)
  );

  pbsr_div u_div (
    .clk_i, .rst_ni, .adv_i(adv),
    .side_i(d_side), .mw_i(d_mw), .chan_i(d_chan),
    .side_o(q_side), .res_o(q_res)
  );

  pbsr_reduce #(
    .VIEW_WIDTH (VIEW_WIDTH),
    .VIEW_HEIGHT(VIEW_HEIGHT)
  ) u_reduce (
    .clk_i, .rst_ni, .adv_i(adv),
    .side_i(q_side), .res_i(q_res),
    .out_valid_o, .projected_o, .view_hit_o,
    .corners_projected_o, .corners_inside_o,
    .depth_min_o, .depth_max_o,
    .pixel_left_o, .pixel_right_o, .pixel_top_o, .pixel_bottom_o
  );

  `PBSR_CHK_IMPL(a_inside_le_proj, out_valid_o, corners_inside_o <= corners_projected_o)
  `PBSR_CHK_IMPL(a_proj_flag, out_valid_o, projected_o == (corners_projected_o != 4'd0))
  `PBSR_CHK_IMPL(a_unproj_zero, out_valid_o && !projected_o, depth_min_o == '0 && pixel_left_o == '0 && !view_hit_o)
  `PBSR_CHK_NEXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o)

endmodule
